@@ hw/rtl/triangle_index_assembly_defines.svh @@
// Assertion macros shared by the triangle index assembler RTL.
// Included by the top level only; depends on nothing else.
`ifndef TRIANGLE_INDEX_ASSEMBLY_DEFINES_SVH
`define TRIANGLE_INDEX_ASSEMBLY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tia_pkg.sv @@
// Types and constants of the triangle index assembler.
// Used by every module of the block; depends on nothing.
package tia_pkg;

    // Result kinds carried in the result transaction.
    typedef enum logic [1:0] {
        KIND_TRI    = 2'd0,
        KIND_END    = 2'd1,
        KIND_RANGE  = 2'd2,
        KIND_LENGTH = 2'd3
    } t_kind;

    // Primitive modes; the unused code behaves as a list.
    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_STRIP = 2'd1;
    localparam logic [1:0] MODE_FAN   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_VCOUNT = 1'b1;

    typedef struct packed {
        logic [31:0] vertex_index;
        logic        last_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] corner_a;
        logic [31:0] corner_b;
        logic [31:0] corner_c;
        logic        end_of_primitive;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ hw/rtl/tia_queue.sv @@
// Small register queue between the front and back halves of the assembler.
// Depends on tia_pkg for the status struct.
module tia_queue #(
    parameter int DATA_W = 34,
    parameter int DEPTH  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [DATA_W-1:0]   i_data,
    input  logic                i_pop,
    output logic [DATA_W-1:0]   o_data,
    output tia_pkg::t_q_status  o_status
);
    import tia_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

@@ hw/rtl/tia_front.sv @@
// Front half: takes index transactions, trims them and checks them against
// the vertex count. Depends on tia_pkg.
module tia_front #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  tia_pkg::t_in_item        i_in_item,
    output logic                     o_in_stall,
    input  logic [31:0]              i_vertex_count,
    input  tia_pkg::t_q_status       i_q_status,
    output logic                     o_push,
    output logic [INDEX_WIDTH+1:0]   o_data
);
    import tia_pkg::*;

    logic                   r_valid, n_valid;
    logic [INDEX_WIDTH-1:0] r_index;
    logic                   r_last;
    logic                   r_out_of_range;
    logic [INDEX_WIDTH-1:0] trimmed;
    logic                   accept;

    assign trimmed    = i_in_item.vertex_index[INDEX_WIDTH-1:0];
    assign o_push     = r_valid && !i_q_status.full;
    assign o_in_stall = r_valid && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_index        <= trimmed;
            r_last         <= i_in_item.last_index;
            r_out_of_range <= (32'(trimmed) >= i_vertex_count);
        end
    end

    assign o_data = {r_out_of_range, r_last, r_index};

endmodule

@@ hw/rtl/tia_back.sv @@
// Back half: holds the assembly state, forms triangles and end or error
// results, and keeps them in the output register. Depends on tia_pkg.
module tia_back #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [1:0]               i_mode,
    input  logic                     i_head_valid,
    input  logic [INDEX_WIDTH+1:0]   i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    output tia_pkg::t_out_item       o_out_item,
    input  logic                     i_out_stall
);
    import tia_pkg::*;

    logic [INDEX_WIDTH-1:0] r_fan_first, n_fan_first;
    logic [INDEX_WIDTH-1:0] r_older, n_older;
    logic [INDEX_WIDTH-1:0] r_newer, n_newer;
    logic [1:0]             r_seen, n_seen;
    logic                   r_odd, n_odd;
    logic [1:0]             r_phase, n_phase;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic [INDEX_WIDTH-1:0] idx;
    logic                   last;
    logic                   out_of_range;
    logic                   connected;
    logic [INDEX_WIDTH-1:0] ca;
    logic                   tri_ok;

    assign {out_of_range, last, idx} = i_head;
    assign connected = (i_mode == MODE_STRIP) || (i_mode == MODE_FAN);
    assign ca        = (i_mode == MODE_FAN) ? r_fan_first : r_older;
    assign tri_ok    = r_seen[1] && (ca != r_newer) && (r_newer != idx) && (ca != idx);

    // Take the head when the output register is free or being drained.
    assign o_pop = i_head_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_fan_first = r_fan_first;
        n_older     = r_older;
        n_newer     = r_newer;
        n_seen      = r_seen;
        n_odd       = r_odd;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (o_pop) begin
            n_out       = '0;
            n_out.end_of_primitive = last;
            n_out_valid = 1'b0;
            if (out_of_range) begin
                n_out.result_kind = KIND_RANGE;
                n_out_valid = 1'b1;
            end else if (connected) begin
                if (tri_ok) begin
                    n_out.result_kind = KIND_TRI;
                    if ((i_mode == MODE_STRIP) && r_odd) begin
                        n_out.corner_a = 32'(r_newer);
                        n_out.corner_b = 32'(ca);
                    end else begin
                        n_out.corner_a = 32'(ca);
                        n_out.corner_b = 32'(r_newer);
                    end
                    n_out.corner_c = 32'(idx);
                    n_out_valid = 1'b1;
                end else if (last) begin
                    n_out.result_kind = KIND_END;
                    n_out_valid = 1'b1;
                end
                if (r_seen == 2'd0) begin
                    n_fan_first = idx;
                end
                n_older = r_newer;
                n_newer = idx;
                if (!r_seen[1]) begin
                    n_seen = r_seen + 2'd1;
                end
                n_odd = !r_odd;
            end else begin
                if (r_phase[1]) begin
                    n_out.result_kind = KIND_TRI;
                    n_out.corner_a = 32'(r_older);
                    n_out.corner_b = 32'(r_newer);
                    n_out.corner_c = 32'(idx);
                    n_out_valid = 1'b1;
                    n_phase = 2'd0;
                end else begin
                    // The first corner of a group fills both pending slots.
                    n_older = r_phase[0] ? r_newer : idx;
                    n_newer = idx;
                    n_phase = r_phase + 2'd1;
                    if (last) begin
                        n_out.result_kind = KIND_LENGTH;
                        n_out_valid = 1'b1;
                    end
                end
            end
            if (out_of_range || last) begin
                n_fan_first = '0;
                n_older     = '0;
                n_newer     = '0;
                n_seen      = '0;
                n_odd       = 1'b0;
                n_phase     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_first <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_seen      <= '0;
            r_odd       <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fan_first <= n_fan_first;
            r_older     <= n_older;
            r_newer     <= n_newer;
            r_seen      <= n_seen;
            r_odd       <= n_odd;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ hw/rtl/triangle_index_assembly.sv @@
// Top level of the triangle index assembler: configuration registers,
// front stage, queue and back stage. Depends on tia_pkg, tia_front,
// tia_queue, tia_back and triangle_index_assembly_defines.svh.
//
//   Channel   Direction  Handshake                Transaction
//   input     in         i_in_valid / o_in_stall  one vertex index and its end flag
//   result    out        o_out_valid / i_out_stall one triangle, end or error result
//   config    in         psel/penable/pwrite      one register write or read
//
// When nothing stalls, the block takes one index per clock; it gives at most one result per clock.
// The edge that accepts an index loads it into the front register; from there
// its result passes through the queue and then into the output register.
// The assembly state lives in the back stage, which settles each index as it pops it,
// so the back stage sets the sustained rate of one index per clock when nothing stalls.
// Reset is synchronous and clears all control and assembly state at once.
// A stall on the result side fills the queue first; the input stalls only when
// the front register holds an index and the queue is full.
module triangle_index_assembly #(
    parameter int INDEX_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Index channel
    input  logic               i_in_valid,
    input  tia_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    // Result channel
    output logic               o_out_valid,
    output tia_pkg::t_out_item o_out_item,
    input  logic               i_out_stall,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tia_pkg::*;

`include "triangle_index_assembly_defines.svh"

    localparam int ENTRY_W = INDEX_WIDTH + 2;

    // Configuration registers. They are to be written only while the block is idle;
    // the block itself does not enforce this, and a write does not disturb the assembly state.
    logic [1:0]  r_mode;
    logic [31:0] r_vertex_count;
    logic        cfg_write;
    logic        reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_LIST;
            r_vertex_count <= '0;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_MODE:   r_mode         <= pwdata[1:0];
                REG_VCOUNT: r_vertex_count <= pwdata;
                default:    r_mode         <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_VCOUNT: prdata = r_vertex_count;
            default:    prdata = '0;
        endcase
    end

    // Front stage: takes an index and checks it against the vertex count.
    logic               q_push;
    logic [ENTRY_W-1:0] q_wr_data;
    logic [ENTRY_W-1:0] q_rd_data;
    logic               q_pop;
    t_q_status          q_status;

    tia_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_item      (i_in_item),
        .o_in_stall     (o_in_stall),
        .i_vertex_count (r_vertex_count),
        .i_q_status     (q_status),
        .o_push         (q_push),
        .o_data         (q_wr_data)
    );

    // The queue decouples the front from a stalled result channel.
    tia_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wr_data),
        .i_pop    (q_pop),
        .o_data   (q_rd_data),
        .o_status (q_status)
    );

    // Back stage: applies the list, strip or fan rules and drives results.
    tia_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_head_valid (!q_status.empty),
        .i_head       (q_rd_data),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

    // The input only stalls behind a full queue.
    `TIA_ASSERT_NOW(a_stall_needs_full, i_clk, i_rst_n, o_in_stall, q_status.full, "input stalled while the queue has room")
    // The front never writes into a full queue.
    `TIA_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_status.full, "push into a full queue")
    // With nothing queued and the output drained, no result can appear.
    `TIA_ASSERT_NEXT(a_no_phantom_result, i_clk, i_rst_n, q_status.empty && (!o_out_valid || !i_out_stall), !o_out_valid, "result without a queued index")

endmodule

@@ bench/triangle_index_assembly_checker.sv @@
`timescale 1ns / 1ps
// Checker for the triangle index assembler: watches the index, result and
// register channels, predicts every result and compares it. Uses tia_pkg.
module triangle_index_assembly_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tia_pkg::t_in_item  i_in_item,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  tia_pkg::t_out_item i_out_item,
    input  logic               i_out_stall,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic [31:0]        i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tia_pkg::*;

    localparam int PRINT_LIMIT = 100;

    // Register copies, kept current by watching the register port.
    logic [1:0]  cfg_mode;
    logic [31:0] cfg_vertex_count;

    // Assembly state.
    logic [31:0] fan_first;
    logic [31:0] older_index;
    logic [31:0] newer_index;
    logic [1:0]  seen_count;
    logic        odd_position;
    logic [1:0]  list_phase;

    t_out_item awaited_results[$];

    task automatic report_mismatch(input string what);
        if (o_fail_count < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic void clear_assembly();
        fan_first    = '0;
        older_index  = '0;
        newer_index  = '0;
        seen_count   = '0;
        odd_position = 1'b0;
        list_phase   = '0;
    endfunction

    // Advances the assembly by one index and queues the result it causes.
    function automatic void assemble_index(input t_in_item item);
        logic [31:0] idx;
        logic [31:0] first_corner;
        logic        last;
        logic        emitted;
        t_out_item   res;
        idx = item.vertex_index;
        last = item.last_index;
        emitted = 1'b0;
        res = '0;
        res.end_of_primitive = last;

        // An index out of range wins over everything and drops the primitive.
        if (idx >= cfg_vertex_count) begin
            res.result_kind = KIND_RANGE;
            awaited_results.insert(awaited_results.size(), res);
            clear_assembly();
            return;
        end

        if (cfg_mode == MODE_STRIP || cfg_mode == MODE_FAN) begin
            if (seen_count == 2'd2) begin
                first_corner = (cfg_mode == MODE_FAN) ? fan_first : older_index;
                // Triangles with two equal corners are dropped.
                if (first_corner != newer_index && newer_index != idx
                        && first_corner != idx) begin
                    res.result_kind = KIND_TRI;
                    if (cfg_mode == MODE_STRIP && odd_position) begin
                        res.corner_a = newer_index;
                        res.corner_b = first_corner;
                    end else begin
                        res.corner_a = first_corner;
                        res.corner_b = newer_index;
                    end
                    res.corner_c = idx;
                    emitted = 1'b1;
                end
            end
            if (seen_count == 2'd0)
                fan_first = idx;
            older_index = newer_index;
            newer_index = idx;
            if (seen_count != 2'd2)
                seen_count++;
            odd_position = ~odd_position;
            if (last && !emitted) begin
                res.result_kind = KIND_END;
                emitted = 1'b1;
            end
        end else begin
            // List mode, which the unused mode code falls back to as well.
            if (list_phase >= 2'd2) begin
                res.result_kind = KIND_TRI;
                res.corner_a = older_index;
                res.corner_b = newer_index;
                res.corner_c = idx;
                emitted = 1'b1;
                list_phase = '0;
            end else begin
                older_index = newer_index;
                newer_index = idx;
                list_phase++;
                if (last) begin
                    res.result_kind = KIND_LENGTH;
                    emitted = 1'b1;
                end
            end
            if (list_phase == 2'd1)
                older_index = idx;
        end

        if (emitted)
            awaited_results.insert(awaited_results.size(), res);
        if (last)
            clear_assembly();
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d with none expected",
                                      got.result_kind));
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %0d, expected %0d",
                                      got.result_kind, want.result_kind));
        if (got.corner_a !== want.corner_a)
            report_mismatch($sformatf("corner_a %h, expected %h",
                                      got.corner_a, want.corner_a));
        if (got.corner_b !== want.corner_b)
            report_mismatch($sformatf("corner_b %h, expected %h",
                                      got.corner_b, want.corner_b));
        if (got.corner_c !== want.corner_c)
            report_mismatch($sformatf("corner_c %h, expected %h",
                                      got.corner_c, want.corner_c));
        if (got.end_of_primitive !== want.end_of_primitive)
            report_mismatch($sformatf("end_of_primitive %b, expected %b",
                                      got.end_of_primitive, want.end_of_primitive));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode = MODE_LIST;
            cfg_vertex_count = '0;
            clear_assembly();
            awaited_results.delete();
        end else begin
            // The result leaving now belongs to an older index, so compare first.
            if (i_out_valid && !i_out_stall)
                check_result(i_out_item);
            if (i_in_valid && !i_in_stall)
                assemble_index(i_in_item);
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_MODE)
                        cfg_mode = i_pwdata[1:0];
                    else
                        cfg_vertex_count = i_pwdata;
                end else if (i_paddr[2] == REG_MODE) begin
                    if (i_prdata[1:0] !== cfg_mode)
                        report_mismatch($sformatf("mode reads %0d, expected %0d",
                                                  i_prdata[1:0], cfg_mode));
                end else if (i_prdata !== cfg_vertex_count) begin
                    report_mismatch($sformatf("vertex count reads %h, expected %h",
                                              i_prdata, cfg_vertex_count));
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ bench/triangle_index_assembly_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the triangle index assembler: clock, reset, stimulus and
// verdict. Depends on tia_pkg, the block and triangle_index_assembly_checker.
module triangle_index_assembly_tb;
    import tia_pkg::*;

    // Register byte addresses: every register fits in 32 bits, so 4 apart.
    localparam logic [2:0] ADDR_MODE   = {REG_MODE, 2'b00};
    localparam logic [2:0] ADDR_VCOUNT = {REG_VCOUNT, 2'b00};
    // The package names no code for the fourth mode; the block treats it as a list.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [31:0] MAX_INDEX       = 32'hFFFF_FFFF;
    localparam int          MAX_GAP         = 18;
    localparam int          RANDOM_INDICES  = 800;
    // Margin for indices that give no result but may still be in flight from the
    // front register through the queue to the output register.
    localparam int          SETTLE_CYCLES   = 12;
    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int          PRESSURE_PHASE  = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_count;

    // Idling switches per phase; off gives back-to-back stretches.
    bit          sender_idles;
    bit          receiver_idles;
    // A long receiver hold-off asked for by the stimulus, served by the receiver.
    int          hold_off_request;
    // Vertex count currently programmed, used to aim indices in or out of range.
    logic [31:0] vertex_limit;
    int          random_sent;

    triangle_index_assembly u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    triangle_index_assembly_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_item   (o_out_item),
        .i_out_stall  (i_out_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // One register transaction: a setup phase, then an access phase that
    // completes at the edge where pready is high.
    task automatic register_transfer(input bit is_write, input logic [2:0] addr,
                                     input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Programs both registers and reads them back; the checker compares the reads.
    task automatic set_registers(input logic [1:0] mode, input logic [31:0] limit);
        register_transfer(1'b1, ADDR_MODE, {30'd0, mode});
        register_transfer(1'b1, ADDR_VCOUNT, limit);
        register_transfer(1'b0, ADDR_MODE, '0);
        register_transfer(1'b0, ADDR_VCOUNT, '0);
        vertex_limit = limit;
    endtask

    // Offers one index, after a random gap while the sender idles, and returns at the edge that takes it.
    // Valid stays high on return, so back-to-back indices need no second update.
    task automatic send_index(input logic [31:0] idx, input logic last);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= {idx, last};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stops offering, waits for every expected result, then lets indices that
    // cause no result drain out of the pipeline.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly in range; one in twenty lands at or above the vertex count, at least half of
    // those exactly on it. Large ranges often reuse a few small indices so that
    // strips and fans meet degenerate triangles.
    function automatic logic [31:0] pick_index(input logic [31:0] limit);
        if (limit == 0)
            return $urandom();
        if ($urandom_range(0, 19) == 0) begin
            if (limit == MAX_INDEX || $urandom_range(0, 1) == 0)
                return limit;
            return $urandom_range(MAX_INDEX, limit);
        end
        if (limit > 32 && $urandom_range(0, 1) == 0)
            return $urandom_range(3, 0);
        return $urandom_range(limit - 1, 0);
    endfunction

    // One primitive of random length. Lists are mostly whole triangles; now and
    // then the end mark is left off so the primitive runs into the next one.
    task automatic send_primitive(input logic [1:0] mode);
        int  length;
        bit  closes;
        if (mode != MODE_STRIP && mode != MODE_FAN && $urandom_range(0, 4) != 0)
            length = 3 * $urandom_range(4, 1);
        else
            length = $urandom_range(12, 1);
        closes = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < length; k++) begin
            send_index(pick_index(vertex_limit), closes && (k == length - 1));
            random_sent++;
        end
    endtask

    // Result side: while the receiver idles, stalls a random number of cycles before taking each result,
    // or serves a long hold-off when the stimulus asks for one.
    initial begin : receiver
        int stall_len;
        i_out_stall = 1'b0;
        forever begin
            if (hold_off_request > 0) begin
                stall_len = hold_off_request;
                hold_off_request = 0;
            end else begin
                stall_len = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        logic [1:0]  mode;
        logic [31:0] limit;
        int          phase_no;
        int          primitives;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in_item        = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        hold_off_request = 0;
        vertex_limit     = '0;
        random_sent      = 0;
        phase_no         = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come out of reset at zero, so every index is out of range.
        register_transfer(1'b0, ADDR_MODE, '0);
        register_transfer(1'b0, ADDR_VCOUNT, '0);
        send_index(32'd0, 1'b0);
        send_index(MAX_INDEX, 1'b1);
        settle();

        // List with the widest range: a triangle at the index extremes, a list
        // cut short by the end mark, and the one index that is still too big.
        set_registers(MODE_LIST, MAX_INDEX);
        send_index(32'd0, 1'b0);
        send_index(32'hFFFF_FFFE, 1'b0);
        send_index(32'h5555_5555, 1'b0);
        send_index(32'hAAAA_AAAA, 1'b0);
        send_index(32'd7, 1'b1);
        send_index(MAX_INDEX, 1'b1);
        settle();

        // Strip: a plain and a swapped triangle, then two degenerate ones, so the
        // end mark comes without a triangle; then a one-index strip.
        set_registers(MODE_STRIP, MAX_INDEX);
        send_index(32'd1, 1'b0);
        send_index(32'd2, 1'b0);
        send_index(32'd3, 1'b0);
        send_index(32'd4, 1'b0);
        send_index(32'd4, 1'b0);
        send_index(32'd5, 1'b1);
        send_index(32'd9, 1'b1);
        settle();

        // Fan: a triangle that closes back on the first index is degenerate, and
        // an out-of-range index in the middle restarts the fan.
        set_registers(MODE_FAN, 32'd100);
        send_index(32'd10, 1'b0);
        send_index(32'd11, 1'b0);
        send_index(32'd12, 1'b0);
        send_index(32'd10, 1'b0);
        send_index(32'd150, 1'b0);
        send_index(32'd13, 1'b1);
        settle();

        // The unused mode code assembles a list.
        set_registers(MODE_UNUSED, 32'd100);
        send_index(32'd20, 1'b0);
        send_index(32'd21, 1'b0);
        send_index(32'd22, 1'b1);
        settle();

        // A mode change halfway through a primitive keeps the state it finds.
        set_registers(MODE_LIST, 32'd100);
        send_index(32'd30, 1'b0);
        settle();
        set_registers(MODE_STRIP, 32'd100);
        send_index(32'd31, 1'b0);
        send_index(32'd32, 1'b1);
        settle();

        // Random phases: a fresh setting each time, then a handful of primitives.
        while (random_sent < RANDOM_INDICES) begin
            phase_no++;
            mode = 2'($urandom_range(3, 0));
            case ($urandom_range(0, 9))
                0:       limit = '0;
                1, 2:    limit = MAX_INDEX;
                3:       limit = $urandom();
                default: limit = $urandom_range(16, 3);
            endcase
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            primitives     = $urandom_range(6, 2);
            if (phase_no == PRESSURE_PHASE) begin
                // Sender runs flat out while the receiver holds off for a long
                // stretch, so the queue fills and the input stalls.
                mode           = MODE_LIST;
                limit          = 32'd12;
                sender_idles   = 1'b0;
                primitives     = 10;
            end
            set_registers(mode, limit);
            if (phase_no == PRESSURE_PHASE)
                hold_off_request = HOLD_OFF_CYCLES;
            repeat (primitives) send_primitive(mode);
            settle();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("triangle_index_assembly_tb: clean");
        end else begin
            $display("triangle_index_assembly_tb: errors");
        end
        $finish;
    end

    // Far beyond the slowest correct run: about a thousand indices, each with the
    // longest gap on both sides and a register phase now and then.
    initial begin : watchdog
        #5_000_000;
        $display("triangle_index_assembly_tb: errors");
        $finish;
    end

endmodule
